[rtl/core/dfstl_pkg.sv]
// ----------------------------------------------------------------------------
// dfstl_pkg: shared types and constants for the DFS topological labeler
// Node and address widths, the sequencer state type and the node count clamp.
// ----------------------------------------------------------------------------
package dfstl_pkg;

  localparam int MAX_NODES = 64;
  // node ids and labels run 1..MAX_NODES, scan position up to MAX_NODES + 1
  localparam int NODE_W    = 7;
  localparam int ADDR_W    = $clog2(MAX_NODES);
  localparam int STK_W     = 2 * NODE_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE_RD,
    S_EDGE_WR,
    S_ROOT,
    S_ROW_RD,
    S_ROW_LD,
    S_SCAN,
    S_POP_LD,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_WAIT
  } dfstl_state_t;

  // zero acts as one node, anything above the matrix size as the matrix size
  function automatic logic [NODE_W-1:0] eff_count(input logic [NODE_W-1:0] v);
    logic [NODE_W-1:0] r;
    r = v;
    if (v == '0) r = NODE_W'(1);
    else if (v > NODE_W'(MAX_NODES)) r = NODE_W'(MAX_NODES);
    return r;
  endfunction

endpackage

[rtl/core/dfstl_ram.sv]
// ----------------------------------------------------------------------------
// dfstl_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dfstl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/dfs_topological_labeler.sv]
// An edge request keeps in_stall high through a row read and a row write; a request
// with neither edge nor done never raises it. A done request runs the search: per
//   node a row read and load, a scan of n+1 positions and a root check, plus a pop
//   and row re-read per return to a parent. Labels then stream out, held by output
//   stall; one request at a time. The scan is bounded by one matrix bit tested per cycle.
// Reset (rst_n low, synchronous): idle, node_count = 64, row_valid and visited cleared.
// ----------------------------------------------------------------------------
// dfs_topological_labeler: topological numbering by depth-first search
// Loads edges into an adjacency RAM, runs an iterative DFS with an explicit
// stack RAM, then streams node labels in node order.
// ----------------------------------------------------------------------------
module dfs_topological_labeler (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [dfstl_pkg::NODE_W-1:0]   cfg_node_count,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_edge_valid,
  input  logic [dfstl_pkg::NODE_W-1:0]   in_source_node,
  input  logic [dfstl_pkg::NODE_W-1:0]   in_target_node,
  input  logic                           in_graph_done,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [dfstl_pkg::NODE_W-1:0]   out_node_id,
  output logic [dfstl_pkg::NODE_W-1:0]   out_order_label,
  output logic                           out_last_label
);
  import dfstl_pkg::*;

  dfstl_state_t           state_r, state_nxt;
  logic [NODE_W-1:0]      node_count_r;
  logic [NODE_W-1:0]      n_eff;
  logic [MAX_NODES-1:0]   visited_r, visited_nxt;
  logic [MAX_NODES-1:0]   row_valid_r, row_valid_nxt;
  logic [NODE_W-1:0]      depth_r, depth_nxt;
  logic [NODE_W-1:0]      next_num_r, next_num_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [NODE_W-1:0]      src_r, src_nxt;
  logic [NODE_W-1:0]      tgt_r, tgt_nxt;
  logic                   done_r, done_nxt;
  logic [MAX_NODES-1:0]   row_r, row_nxt;
  logic [NODE_W-1:0]      cur_u_r, cur_u_nxt;
  logic [NODE_W-1:0]      cur_j_r, cur_j_nxt;
  logic [NODE_W-1:0]      root_r, root_nxt;
  logic [NODE_W-1:0]      out_node_r, out_node_nxt;
  logic [NODE_W-1:0]      out_label_r, out_label_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [ADDR_W-1:0]      sidx, tidx, uidx, jidx, ridx;

  logic                   adj_we, adj_re;
  logic [ADDR_W-1:0]      adj_waddr, adj_raddr;
  logic [MAX_NODES-1:0]   adj_wdata, adj_rdata;
  logic                   lab_we, lab_re;
  logic [ADDR_W-1:0]      lab_waddr, lab_raddr;
  logic [NODE_W-1:0]      lab_wdata, lab_rdata;
  logic                   stk_we, stk_re;
  logic [ADDR_W-1:0]      stk_waddr, stk_raddr;
  logic [STK_W-1:0]       stk_wdata, stk_rdata;

  assign n_eff = eff_count(node_count_r);
  // node k lives at address k-1
  assign sidx  = ADDR_W'(src_r - NODE_W'(1));
  assign tidx  = ADDR_W'(tgt_r - NODE_W'(1));
  assign uidx  = ADDR_W'(cur_u_r - NODE_W'(1));
  assign jidx  = ADDR_W'(cur_j_r - NODE_W'(1));
  assign ridx  = ADDR_W'(root_r - NODE_W'(1));

  dfstl_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .re    (adj_re),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  dfstl_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_label_ram (
    .clk   (clk),
    .we    (lab_we),
    .waddr (lab_waddr),
    .wdata (lab_wdata),
    .re    (lab_re),
    .raddr (lab_raddr),
    .rdata (lab_rdata)
  );

  // entry = {node, resume scan position}
  dfstl_ram #(.WIDTH(STK_W), .DEPTH(MAX_NODES)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= NODE_W'(MAX_NODES);
      visited_r    <= '0;
      row_valid_r  <= '0;
      depth_r      <= '0;
      next_num_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_wr_en) begin
        node_count_r <= cfg_node_count;
      end
      visited_r    <= visited_nxt;
      row_valid_r  <= row_valid_nxt;
      depth_r      <= depth_nxt;
      next_num_r   <= next_num_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r       <= src_nxt;
    tgt_r       <= tgt_nxt;
    done_r      <= done_nxt;
    row_r       <= row_nxt;
    cur_u_r     <= cur_u_nxt;
    cur_j_r     <= cur_j_nxt;
    root_r      <= root_nxt;
    out_node_r  <= out_node_nxt;
    out_label_r <= out_label_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    visited_nxt   = visited_r;
    row_valid_nxt = row_valid_r;
    depth_nxt     = depth_r;
    next_num_nxt  = next_num_r;
    out_valid_nxt = out_valid_r;
    src_nxt       = src_r;
    tgt_nxt       = tgt_r;
    done_nxt      = done_r;
    row_nxt       = row_r;
    cur_u_nxt     = cur_u_r;
    cur_j_nxt     = cur_j_r;
    root_nxt      = root_r;
    out_node_nxt  = out_node_r;
    out_label_nxt = out_label_r;
    out_last_nxt  = out_last_r;
    adj_we    = 1'b0;
    adj_waddr = sidx;
    adj_wdata = '0;
    adj_re    = 1'b0;
    adj_raddr = uidx;
    lab_we    = 1'b0;
    lab_waddr = uidx;
    lab_wdata = next_num_r;
    lab_re    = 1'b0;
    lab_raddr = ridx;
    stk_we    = 1'b0;
    stk_waddr = depth_r[ADDR_W-1:0];
    stk_wdata = {cur_u_r, cur_j_r + NODE_W'(1)};
    stk_re    = 1'b0;
    stk_raddr = ADDR_W'(depth_r - NODE_W'(1));

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          src_nxt  = in_source_node;
          tgt_nxt  = in_target_node;
          done_nxt = in_graph_done;
          if (in_edge_valid && (in_source_node inside {[1:MAX_NODES]}) &&
              (in_target_node inside {[1:MAX_NODES]})) begin
            state_nxt = S_EDGE_RD;
          end else if (in_graph_done) begin
            root_nxt     = NODE_W'(1);
            next_num_nxt = n_eff;
            state_nxt    = S_ROOT;
          end
        end
      end
      S_EDGE_RD: begin
        adj_re    = 1'b1;
        adj_raddr = sidx;
        state_nxt = S_EDGE_WR;
      end
      S_EDGE_WR: begin
        // read-modify-write; a row never written since the last clear reads as zero
        adj_we    = 1'b1;
        adj_waddr = sidx;
        adj_wdata = (row_valid_r[sidx] ? adj_rdata : '0) | (MAX_NODES'(1) << tidx);
        row_valid_nxt[sidx] = 1'b1;
        if (done_r) begin
          root_nxt     = NODE_W'(1);
          next_num_nxt = n_eff;
          state_nxt    = S_ROOT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ROOT: begin
        if (root_r > n_eff) begin
          root_nxt  = NODE_W'(1);
          state_nxt = S_OUT_RD;
        end else if (visited_r[ridx]) begin
          root_nxt = root_r + NODE_W'(1);
        end else begin
          visited_nxt[ridx] = 1'b1;
          cur_u_nxt = root_r;
          cur_j_nxt = NODE_W'(1);
          depth_nxt = '0;
          state_nxt = S_ROW_RD;
        end
      end
      S_ROW_RD: begin
        adj_re    = 1'b1;
        adj_raddr = uidx;
        state_nxt = S_ROW_LD;
      end
      S_ROW_LD: begin
        row_nxt   = row_valid_r[uidx] ? adj_rdata : '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (cur_j_r > n_eff) begin
          // node finished: take the next label, return to parent or, at the top, to the root search
          lab_we    = 1'b1;
          lab_waddr = uidx;
          lab_wdata = next_num_r;
          if (next_num_r != '0) begin
            next_num_nxt = next_num_r - NODE_W'(1);
          end
          if (depth_r == '0) begin
            state_nxt = S_ROOT;
          end else begin
            depth_nxt = depth_r - NODE_W'(1);
            stk_re    = 1'b1;
            stk_raddr = ADDR_W'(depth_r - NODE_W'(1));
            state_nxt = S_POP_LD;
          end
        end else if (row_r[jidx] && !visited_r[jidx]) begin
          stk_we    = 1'b1;
          stk_waddr = depth_r[ADDR_W-1:0];
          stk_wdata = {cur_u_r, cur_j_r + NODE_W'(1)};
          depth_nxt = depth_r + NODE_W'(1);
          visited_nxt[jidx] = 1'b1;
          cur_u_nxt = cur_j_r;
          cur_j_nxt = NODE_W'(1);
          state_nxt = S_ROW_RD;
        end else begin
          cur_j_nxt = cur_j_r + NODE_W'(1);
        end
      end
      S_POP_LD: begin
        cur_u_nxt = stk_rdata[STK_W-1:NODE_W];
        cur_j_nxt = stk_rdata[NODE_W-1:0];
        state_nxt = S_ROW_RD;
      end
      S_OUT_RD: begin
        lab_re    = 1'b1;
        lab_raddr = ridx;
        state_nxt = S_OUT_LD;
      end
      S_OUT_LD: begin
        out_valid_nxt = 1'b1;
        out_node_nxt  = root_r;
        out_label_nxt = lab_rdata;
        out_last_nxt  = (root_r == n_eff);
        state_nxt     = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            visited_nxt   = '0;
            row_valid_nxt = '0;
            state_nxt     = S_IDLE;
          end else begin
            root_nxt  = root_r + NODE_W'(1);
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_node_id     = out_node_r;
  assign out_order_label = out_label_r;
  assign out_last_label  = out_last_r;

  // a label is only shown while the input side is held off
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while a label is pending");

  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_OUT_WAIT))
    else $error("output valid outside the output wait state");

  // while scanning, the stack depth stays below the node count
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (depth_r < n_eff))
    else $error("stack depth out of range");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_label) |=>
      ((visited_r == '0) && (row_valid_r == '0) && (state_r == S_IDLE)))
    else $error("graph state not cleared after the last label");

endmodule

[tb/dfs_topological_labeler_tb.sv]
// ----------------------------------------------------------------------------
// dfs_topological_labeler_tb: self-checking bench for the DFS topological labeler
// Loads edge lists, fires graph_done and compares every streamed label against
// an in-bench depth-first numbering. Directed corner graphs first, then random
// graphs under several sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module dfs_topological_labeler_tb;
  import dfstl_pkg::*;

  typedef struct packed {
    logic [NODE_W-1:0] node_id;
    logic [NODE_W-1:0] order_label;
    logic              last_label;
  } node_label_t;

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              cfg_wr_en       = 1'b0;
  logic [NODE_W-1:0] cfg_node_count  = '0;
  logic              in_valid        = 1'b0;
  logic              in_stall;
  logic              in_edge_valid   = 1'b0;
  logic [NODE_W-1:0] in_source_node  = '0;
  logic [NODE_W-1:0] in_target_node  = '0;
  logic              in_graph_done   = 1'b0;
  logic              out_valid;
  logic              out_stall       = 1'b0;
  logic [NODE_W-1:0] out_node_id;
  logic [NODE_W-1:0] out_order_label;
  logic              out_last_label;

  // shadow of the labeler state
  bit [MAX_NODES:1]  adj_rows [1:MAX_NODES];
  bit [MAX_NODES:1]  visited_nodes;
  logic [NODE_W-1:0] node_labels [1:MAX_NODES];
  logic [NODE_W-1:0] node_count_reg = NODE_W'(MAX_NODES);

  node_label_t pending_labels[$];
  node_label_t head_label;
  int          error_count   = 0;
  int          request_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;

  dfs_topological_labeler dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_node_count  (cfg_node_count),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_edge_valid   (in_edge_valid),
    .in_source_node  (in_source_node),
    .in_target_node  (in_target_node),
    .in_graph_done   (in_graph_done),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_node_id     (out_node_id),
    .out_order_label (out_order_label),
    .out_last_label  (out_last_label)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_labels.size() == 0) begin
        report_mismatch($sformatf("unexpected label for node %0d", out_node_id));
      end else begin
        head_label = pending_labels.pop_front();
        if (out_node_id !== head_label.node_id)
          report_mismatch($sformatf("node_id %0d, want %0d", out_node_id, head_label.node_id));
        if (out_order_label !== head_label.order_label)
          report_mismatch($sformatf("node %0d label %0d, want %0d", head_label.node_id,
                                    out_order_label, head_label.order_label));
        if (out_last_label !== head_label.last_label)
          report_mismatch($sformatf("node %0d last flag %b, want %b", head_label.node_id,
                                    out_last_label, head_label.last_label));
      end
    end
  end

  // Iterative DFS with explicit stack; labels count down from n at node finish.
  function automatic void predict_labels(input bit ev, input logic [NODE_W-1:0] src,
                                         input logic [NODE_W-1:0] dst, input bit done);
    int n, num, depth, u, j;
    int stk_node [0:MAX_NODES-1];
    int stk_pos  [0:MAX_NODES-1];
    bit pushed;
    node_label_t lbl;
    if (ev && src >= 1 && src <= MAX_NODES && dst >= 1 && dst <= MAX_NODES)
      adj_rows[src][dst] = 1'b1;
    if (!done) return;
    if (node_count_reg == 0) n = 1;
    else if (node_count_reg > MAX_NODES) n = MAX_NODES;
    else n = node_count_reg;
    num = n;
    for (int root = 1; root <= n; root++) begin
      if (!visited_nodes[root]) begin
        visited_nodes[root] = 1'b1;
        depth = 1;
        stk_node[0] = root;
        stk_pos[0] = 1;
        while (depth > 0) begin
          u = stk_node[depth-1];
          j = stk_pos[depth-1];
          pushed = 1'b0;
          while (j <= n && !pushed) begin
            if (adj_rows[u][j] && !visited_nodes[j]) begin
              stk_pos[depth-1] = j + 1;
              visited_nodes[j] = 1'b1;
              stk_node[depth] = j;
              stk_pos[depth] = 1;
              depth++;
              pushed = 1'b1;
            end else begin
              j++;
            end
          end
          if (!pushed) begin
            node_labels[u] = NODE_W'(num);
            num--;
            depth--;
          end
        end
      end
    end
    for (int i = 1; i <= n; i++) begin
      lbl.node_id     = NODE_W'(i);
      lbl.order_label = node_labels[i];
      lbl.last_label  = (i == n);
      pending_labels.push_back(lbl);
    end
    foreach (adj_rows[r]) adj_rows[r] = '0;
    visited_nodes = '0;
  endfunction

  // Called at a rising edge; returns at the edge where the request was taken.
  task automatic send_request(input bit ev, input logic [NODE_W-1:0] src,
                              input logic [NODE_W-1:0] dst, input bit done);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_edge_valid  <= ev;
    in_source_node <= src;
    in_target_node <= dst;
    in_graph_done  <= done;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_labels(ev, src, dst, done);
    if (ev || done) request_count++;
  endtask

  // Hold off until every label is back and the clear-down has had time to finish.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_labels.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [NODE_W-1:0] value);
    wait_drained();
    cfg_wr_en      <= 1'b1;
    cfg_node_count <= value;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    node_count_reg = value;
  endtask

  // Reset node count of 64: self loop, two-node cycle, rejected node ids,
  // edge and done in one request.
  task automatic test_default_count();
    wait_drained();
    send_request(1'b1, 7'd1, 7'd64, 1'b0);
    send_request(1'b1, 7'd64, 7'd64, 1'b0);
    send_request(1'b1, 7'd0, 7'd5, 1'b0);
    send_request(1'b1, 7'd5, 7'd65, 1'b0);
    send_request(1'b1, 7'd127, 7'd127, 1'b0);
    send_request(1'b1, 7'd2, 7'd1, 1'b0);
    send_request(1'b1, 7'd1, 7'd2, 1'b0);
    send_request(1'b1, 7'd63, 7'd64, 1'b1);
  endtask

  // Zero acts as one node, values above the matrix size act as the matrix size.
  task automatic test_count_clamp();
    write_node_count(7'd0);
    send_request(1'b1, 7'd1, 7'd1, 1'b1);
    write_node_count(7'd127);
    send_request(1'b1, 7'd64, 7'd1, 1'b0);
    send_request(1'b0, 7'd127, 7'd127, 1'b1);
    write_node_count(7'd1);
    send_request(1'b0, 7'd0, 7'd0, 1'b1);
  endtask

  // Cycle, repeated edge, edge to a node above n, request with neither flag.
  task automatic test_cycles_and_bad_edges();
    write_node_count(7'd6);
    send_request(1'b1, 7'd1, 7'd2, 1'b0);
    send_request(1'b1, 7'd2, 7'd3, 1'b0);
    send_request(1'b1, 7'd3, 7'd1, 1'b0);
    send_request(1'b1, 7'd1, 7'd2, 1'b0);
    send_request(1'b1, 7'd4, 7'd9, 1'b0);
    send_request(1'b1, 7'd6, 7'd5, 1'b0);
    send_request(1'b0, 7'd6, 7'd4, 1'b0);
    send_request(1'b1, 7'd5, 7'd0, 1'b0);
    send_request(1'b0, 7'd64, 7'd33, 1'b1);
  endtask

  task automatic run_random_graph();
    int pick, cfg, n, edge_total, r, a, b;
    bit done_sent;
    pick = $urandom_range(19);
    if (pick == 0) cfg = MAX_NODES;
    else if (pick == 1) cfg = $urandom_range(1) ? 0 : $urandom_range(127, 65);
    else if (pick <= 3) cfg = $urandom_range(40, 13);
    else cfg = $urandom_range(12, 1);
    n = (cfg == 0) ? 1 : (cfg > MAX_NODES) ? MAX_NODES : cfg;
    write_node_count(NODE_W'(cfg));
    edge_total = $urandom_range((n < 8) ? 2 * n : 16, 0);
    done_sent = 1'b0;
    for (int k = 0; k < edge_total; k++) begin
      // stray request that neither loads an edge nor starts the search
      if ($urandom_range(9) == 0)
        send_request(1'b0, NODE_W'($urandom_range(127)), NODE_W'($urandom_range(127)), 1'b0);
      r = $urandom_range(99);
      if (r < 65) begin
        // forward edge (a < b), or a self loop when n is 1
        if (n == 1) begin
          a = 1;
          b = 1;
        end else begin
          a = $urandom_range(n - 1, 1);
          b = $urandom_range(n, a + 1);
        end
      end else if (r < 85) begin
        a = $urandom_range(n, 1);
        b = $urandom_range(n, 1);
      end else if (r < 93) begin
        a = $urandom_range(MAX_NODES, 1);
        b = $urandom_range(MAX_NODES, 1);
      end else begin
        a = $urandom_range(127);
        b = $urandom_range(127);
      end
      done_sent = (k == edge_total - 1) && $urandom_range(1);
      send_request(1'b1, NODE_W'(a), NODE_W'(b), done_sent);
    end
    if (!done_sent)
      send_request(1'b0, NODE_W'($urandom_range(127)), NODE_W'($urandom_range(127)), 1'b1);
  endtask

  task automatic test_random_graphs();
    int target;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 86; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 86; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      target = request_count + 42;
      while (request_count < target) run_random_graph();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_default_count();
    test_count_clamp();
    test_cycles_and_bad_edges();
    test_random_graphs();
    wait_drained();
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("TIMEOUT: %0d labels still pending", pending_labels.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

[dfs_topological_labeler.f]
rtl/core/dfstl_pkg.sv
rtl/core/dfstl_ram.sv
rtl/core/dfs_topological_labeler.sv
tb/dfs_topological_labeler_tb.sv
